FILE: design/gfpt_pkg.sv
// ----------------------------------------------------------------------------
// gfpt_pkg: shared types and constants of the gait phase tracker
// Q1.16 fractions, phase codes and the request/response of the ratio unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gfpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;   // Q1.16 fraction
  localparam int TIME_W    = FRAC_BITS;       // Q0.16 cycle time
  localparam int ARG_W     = FRAC_BITS + 4;   // signed ratio operands
  localparam int REM_W     = FRAC_BITS + 2;   // divider remainder and divisor
  localparam int POS_W     = 32;

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] T10 = Q_W'(((64'd1 << FRAC_BITS) * 10 + 50) / 100);
  localparam logic [Q_W-1:0] T85 = Q_W'(((64'd1 << FRAC_BITS) * 85 + 50) / 100);
  localparam logic [Q_W-1:0] T70 = Q_W'(((64'd1 << FRAC_BITS) * 70 + 50) / 100);

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_L_CONTACT = 3'd1;
  localparam logic [2:0] REG_L_LIFT    = 3'd2;
  localparam logic [2:0] REG_R_CONTACT = 3'd3;
  localparam logic [2:0] REG_R_LIFT    = 3'd4;

  typedef enum logic [1:0] {
    PH_SWING   = 2'd0,
    PH_CONTACT = 2'd1,
    PH_STANCE  = 2'd2,
    PH_PUSHOFF = 2'd3
  } phase_t;

  typedef struct packed {
    logic                    start;
    logic signed [ARG_W-1:0] num;
    logic signed [ARG_W-1:0] den;
  } ratio_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } ratio_rsp_t;

endpackage

`default_nettype wire

FILE: design/gfpt_ratio.sv
// ----------------------------------------------------------------------------
// gfpt_ratio: shared saturating ratio unit
// Gives clamp(num * ONE / den, 0, ONE); zero or negative divisor gives ONE.
// Restoring division, two quotient bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpt_ratio (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gfpt_pkg::ratio_req_t req,
  output gfpt_pkg::ratio_rsp_t      rsp
);

  localparam int STEPS = gfpt_pkg::FRAC_BITS / 2;
  localparam int CW    = $clog2(STEPS);
  localparam int RW    = gfpt_pkg::REM_W;
  localparam int QW    = gfpt_pkg::Q_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic [QW-1:0] quo;

  logic [RW:0]   sh_a;
  logic [RW:0]   sh_b;
  logic          ge_a;
  logic          ge_b;
  logic [RW-1:0] rem_a;
  logic [RW-1:0] rem_b;

  always_comb begin
    sh_a  = {rem, 1'b0};
    ge_a  = sh_a >= {1'b0, dvs};
    rem_a = ge_a ? RW'(sh_a - {1'b0, dvs}) : sh_a[RW-1:0];
    sh_b  = {rem_a, 1'b0};
    ge_b  = sh_b >= {1'b0, dvs};
    rem_b = ge_b ? RW'(sh_b - {1'b0, dvs}) : sh_b[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.den <= $signed(gfpt_pkg::ARG_W'(0))) begin
          quo  <= gfpt_pkg::ONE;
          done <= 1'b1;
        end else if (req.num <= $signed(gfpt_pkg::ARG_W'(0))) begin
          quo  <= '0;
          done <= 1'b1;
        end else if (req.num >= req.den) begin
          quo  <= gfpt_pkg::ONE;
          done <= 1'b1;
        end else begin
          rem  <= req.num[RW-1:0];
          dvs  <= req.den[RW-1:0];
          quo  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_b;
        quo <= {quo[QW-3:0], ge_a, ge_b};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

FILE: design/foot_gait_phase_tracker_top.sv
// ----------------------------------------------------------------------------
// foot_gait_phase_tracker_top: per-foot gait phase tracker
// Classifies each item into swing, contact, stance or push-off, tracks phase
// progress, latches the foot position at first contact, gives IK/lock blends.
//
//   channel  dir  handshake          payload
//   s        in   s_tvalid/s_tready  s_tdata, s_tuser
//   m        out  m_tvalid/m_tready  m_tdata
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// Enabled, an item takes at most two ratios in the shared divider (two
// quotient bits a cycle; a ratio that saturates skips the division).
// Disabled, the foot state is kept and the divider is used only when the
// swing IK weight needs it.
// One item at a time; s_tready is low until the result is taken.
// Synchronous reset returns both feet to swing with state cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module foot_gait_phase_tracker_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,   // cycle_time, pos_x, pos_y, pos_z
  input  wire logic [0:0]   s_tuser,   // foot_select
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // phase, phase_progress, grounded, lock_valid, lock_x, lock_y, lock_z,
  // last_contact, last_lift, ik_weight, lock_blend, zero pad
  output logic [183:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [16:0]  cfg_data
);

  localparam int QW = gfpt_pkg::Q_W;
  localparam int TW = gfpt_pkg::TIME_W;
  localparam int AW = gfpt_pkg::ARG_W;
  localparam int PW = gfpt_pkg::POS_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_MID    = 7'b0001000,
    ST_COMMIT = 7'b0010000,
    ST_IK     = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    DS_SP    = 2'd0,
    DS_PHASE = 2'd1,
    DS_IK    = 2'd2
  } div_stage_t;

  state_t     state;
  div_stage_t stage;

  // configuration
  logic          enable;
  logic [QW-1:0] cfg_contact [2];
  logic [QW-1:0] cfg_lift    [2];

  // per-foot state
  gfpt_pkg::phase_t phase_st   [2];
  logic [QW-1:0]    progress   [2];
  logic             grounded   [2];
  logic             lock_valid [2];
  logic [PW-1:0]    lock_x     [2];
  logic [PW-1:0]    lock_y     [2];
  logic [PW-1:0]    lock_z     [2];
  logic [TW-1:0]    last_cont  [2];
  logic [TW-1:0]    last_lift  [2];

  // item registers
  logic          foot;
  logic [TW-1:0] t_in;
  logic [PW-1:0] px;
  logic [PW-1:0] py;
  logic [PW-1:0] pz;
  logic          stance_r;
  logic [QW-1:0] res;
  logic [QW-1:0] ik_r;
  logic [QW-1:0] lb_r;
  gfpt_pkg::phase_t new_phase;

  gfpt_pkg::ratio_req_t req;
  gfpt_pkg::ratio_rsp_t rsp;

  gfpt_ratio u_ratio (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // window and first ratio operands
  logic signed [AW-1:0] c_s;
  logic signed [AW-1:0] l_s;
  logic signed [AW-1:0] t_s;
  logic signed [AW-1:0] one_s;
  logic                 wrap;
  logic                 in_stance;
  logic signed [AW-1:0] prep_num;
  logic signed [AW-1:0] prep_den;

  always_comb begin
    c_s   = $signed(AW'(cfg_contact[foot]));
    l_s   = $signed(AW'(cfg_lift[foot]));
    t_s   = $signed(AW'(t_in));
    one_s = $signed(AW'(gfpt_pkg::ONE));
    wrap  = l_s < c_s;
    in_stance = wrap ? (t_s >= c_s || t_s < l_s) : (t_s >= c_s && t_s < l_s);
    if (in_stance) begin
      prep_den = wrap ? (one_s - c_s) + l_s : l_s - c_s;
      prep_num = (wrap && t_s < c_s) ? (one_s - c_s) + t_s : t_s - c_s;
    end else begin
      prep_den = wrap ? c_s - l_s : one_s - (l_s - c_s);
      prep_num = (!wrap && t_s < l_s) ? (one_s - l_s) + t_s : t_s - l_s;
    end
  end

  // sub-phase split of the stance progress
  gfpt_pkg::phase_t     mid_phase;
  logic signed [AW-1:0] mid_num;
  logic signed [AW-1:0] mid_den;
  logic signed [AW-1:0] sp_s;

  always_comb begin
    sp_s = $signed(AW'(res));
    if (res < gfpt_pkg::T10) begin
      mid_phase = gfpt_pkg::PH_CONTACT;
      mid_num   = sp_s;
      mid_den   = $signed(AW'(gfpt_pkg::T10));
    end else if (res > gfpt_pkg::T85) begin
      mid_phase = gfpt_pkg::PH_PUSHOFF;
      mid_num   = sp_s - $signed(AW'(gfpt_pkg::T85));
      mid_den   = $signed(AW'(gfpt_pkg::ONE - gfpt_pkg::T85));
    end else begin
      mid_phase = gfpt_pkg::PH_STANCE;
      mid_num   = sp_s - $signed(AW'(gfpt_pkg::T10));
      mid_den   = $signed(AW'(gfpt_pkg::T85 - gfpt_pkg::T10));
    end
  end

  gfpt_pkg::phase_t cur_phase;
  logic [QW-1:0]    cur_p;
  logic             ik_div;

  always_comb begin
    cur_phase = phase_st[foot];
    cur_p     = progress[foot];
    ik_div    = (cur_phase == gfpt_pkg::PH_SWING) && (cur_p > gfpt_pkg::T70);
  end

  always_comb begin
    req.start = 1'b0;
    req.num   = prep_num;
    req.den   = prep_den;
    if (state == ST_PREP) begin
      req.start = enable;
    end else if (state == ST_MID) begin
      req.start = stance_r;
      req.num   = mid_num;
      req.den   = mid_den;
    end else if (state == ST_IK) begin
      req.start = ik_div;
      req.num   = $signed(AW'(cur_p)) - $signed(AW'(gfpt_pkg::T70));
      req.den   = $signed(AW'(gfpt_pkg::ONE - gfpt_pkg::T70));
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      cfg_contact[0] <= '0;
      cfg_lift[0]    <= gfpt_pkg::ONE;
      cfg_contact[1] <= '0;
      cfg_lift[1]    <= gfpt_pkg::ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfpt_pkg::REG_ENABLE:    enable         <= cfg_data[0];
        gfpt_pkg::REG_L_CONTACT: cfg_contact[0] <= cfg_data;
        gfpt_pkg::REG_L_LIFT:    cfg_lift[0]    <= cfg_data;
        gfpt_pkg::REG_R_CONTACT: cfg_contact[1] <= cfg_data;
        gfpt_pkg::REG_R_LIFT:    cfg_lift[1]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and foot state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= DS_SP;
      for (int i = 0; i < 2; i++) begin
        phase_st[i]   <= gfpt_pkg::PH_SWING;
        progress[i]   <= '0;
        grounded[i]   <= 1'b0;
        lock_valid[i] <= 1'b0;
        lock_x[i]     <= '0;
        lock_y[i]     <= '0;
        lock_z[i]     <= '0;
        last_cont[i]  <= '0;
        last_lift[i]  <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            foot  <= s_tuser[0];
            t_in  <= s_tdata[15:0];
            px    <= s_tdata[47:16];
            py    <= s_tdata[79:48];
            pz    <= s_tdata[111:80];
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          stance_r <= in_stance;
          stage    <= DS_SP;
          state    <= enable ? ST_DIV : ST_IK;
        end
        ST_DIV: begin
          if (rsp.done) begin
            res <= rsp.quo;
            unique case (stage)
              DS_SP:    state <= ST_MID;
              DS_PHASE: state <= ST_COMMIT;
              default: begin
                ik_r  <= rsp.quo;
                lb_r  <= '0;
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_MID: begin
          if (stance_r) begin
            new_phase <= mid_phase;
            stage     <= DS_PHASE;
            state     <= ST_DIV;
          end else begin
            phase_st[foot]   <= gfpt_pkg::PH_SWING;
            progress[foot]   <= res;
            grounded[foot]   <= 1'b0;
            lock_valid[foot] <= 1'b0;
            if (phase_st[foot] != gfpt_pkg::PH_SWING) begin
              last_lift[foot] <= t_in;
            end
            state <= ST_IK;
          end
        end
        ST_COMMIT: begin
          phase_st[foot] <= new_phase;
          progress[foot] <= res;
          grounded[foot] <= 1'b1;
          // first contact of this stance
          if ((phase_st[foot] == gfpt_pkg::PH_SWING ||
               phase_st[foot] == gfpt_pkg::PH_CONTACT) &&
              new_phase == gfpt_pkg::PH_CONTACT && !lock_valid[foot]) begin
            lock_x[foot]     <= px;
            lock_y[foot]     <= py;
            lock_z[foot]     <= pz;
            lock_valid[foot] <= 1'b1;
            last_cont[foot]  <= t_in;
          end
          state <= ST_IK;
        end
        ST_IK: begin
          unique case (cur_phase)
            gfpt_pkg::PH_SWING: begin
              ik_r <= '0;
              lb_r <= '0;
            end
            gfpt_pkg::PH_CONTACT: begin
              ik_r <= cur_p;
              lb_r <= cur_p;
            end
            gfpt_pkg::PH_STANCE: begin
              ik_r <= gfpt_pkg::ONE;
              lb_r <= gfpt_pkg::ONE;
            end
            default: begin
              ik_r <= gfpt_pkg::ONE - cur_p;
              lb_r <= gfpt_pkg::ONE - (cur_p >> 1);
            end
          endcase
          if (ik_div) begin
            stage <= DS_IK;
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {1'b0, lb_r, ik_r, last_lift[foot], last_cont[foot],
                     lock_z[foot], lock_y[foot], lock_x[foot],
                     lock_valid[foot], grounded[foot], progress[foot],
                     phase_st[foot]};

endmodule

`default_nettype wire
